### src/cae_pkg.sv
// Shared types, codes and helper functions for the clock and alarm setting editor.
`default_nettype none

package cae_pkg;

   typedef enum logic [2:0] {
      FUNC_MODE  = 3'd0,
      FUNC_INCR  = 3'd1,
      FUNC_DECR  = 3'd2,
      FUNC_SAVE  = 3'd3,
      FUNC_EXIT  = 3'd4,
      FUNC_ALARM = 3'd5,
      FUNC_PAGE  = 3'd6,
      FUNC_LOAD  = 3'd7
   } func_type;

   // cursor codes in time edit
   localparam logic [2:0] CUR_NONE   = 3'd0;
   localparam logic [2:0] CUR_YEAR   = 3'd1;
   localparam logic [2:0] CUR_MONTH  = 3'd2;
   localparam logic [2:0] CUR_DATE   = 3'd3;
   localparam logic [2:0] CUR_HOUR   = 3'd4;
   localparam logic [2:0] CUR_MINUTE = 3'd5;
   localparam logic [2:0] CUR_SECOND = 3'd6;
   // cursor codes in alarm edit
   localparam logic [2:0] CUR_ALARM_HOUR   = 3'd1;
   localparam logic [2:0] CUR_ALARM_MINUTE = 3'd2;

   localparam logic [1:0] PAGE_TIME  = 2'd0;
   localparam logic [1:0] PAGE_DATE  = 2'd1;
   localparam logic [1:0] PAGE_ALARM = 2'd3;

   localparam logic [6:0] YEAR_MAX   = 7'd99;
   localparam logic [6:0] MONTH_MAX  = 7'd12;
   localparam logic [6:0] HOUR_MAX   = 7'd23;
   localparam logic [6:0] MINUTE_MAX = 7'd59;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [4:0] date;
      logic [3:0] month;
      logic [6:0] year;
      logic [4:0] alarm_hour;
      logic [5:0] alarm_minute;
   } fields_type;

   typedef struct packed {
      logic       time_edit;
      logic       alarm_edit;
      logic [2:0] cursor;
      logic       up;
   } adjust_ctl_type;

   function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] lo,
                                          input logic [6:0] hi);
      logic [7:0] sum;
      sum = {1'b0, v} + 8'd1;
      return (sum > {1'b0, hi}) ? lo : sum[6:0];
   endfunction

   function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] lo,
                                            input logic [6:0] hi);
      return (v <= lo) ? hi : v - 7'd1;
   endfunction

   // month outside 1..12 takes the February length
   function automatic logic [6:0] month_length(input logic [3:0] m, input logic [6:0] y);
      logic [6:0] len;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11:                  len = 7'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 7'd31;
         default:                                  len = (y[1:0] == 2'b00) ? 7'd29 : 7'd28;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### src/clock_alarm_setting_editor.sv
// Top level: event decode, editor state and result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_func, req_load_*
//   rsp      out        rsp_valid / rsp_ready  rsp_cur_*, rsp_wake_*, rsp_cursor,
//                                              rsp_edit_modes, rsp_page, rsp_flags
//
// One event per cycle: the state registers update at the transfer and the
// result is visible on rsp_* the next cycle.
// req_ready is high whenever the result slot is empty or being taken, so a
// stalled rsp side holds the request side only while a result is pending.
// Synchronous reset loads the power-up time 23:59:50, day 6, month 12, year 21.
`default_nettype none

module clock_alarm_setting_editor
   import cae_pkg::*;
(
   input  wire        clock,
   input  wire        reset,

   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [2:0] req_func,
   input  wire  [5:0] req_load_second,
   input  wire  [5:0] req_load_minute,
   input  wire  [4:0] req_load_hour,
   input  wire  [4:0] req_load_date,
   input  wire  [3:0] req_load_month,
   input  wire  [6:0] req_load_year,

   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [4:0] rsp_cur_hour,
   output logic [5:0] rsp_cur_minute,
   output logic [5:0] rsp_cur_second,
   output logic [4:0] rsp_cur_date,
   output logic [3:0] rsp_cur_month,
   output logic [6:0] rsp_cur_year,
   output logic [4:0] rsp_wake_hour,
   output logic [5:0] rsp_wake_minute,
   output logic [2:0] rsp_cursor,
   output logic [1:0] rsp_edit_modes,
   output logic [1:0] rsp_page,
   output logic [2:0] rsp_flags
);

   fields_type     fields_ff, fields_in, adjusted;
   adjust_ctl_type adj_ctl;
   logic           time_edit_ff, time_edit_in;
   logic           alarm_edit_ff, alarm_edit_in;
   logic [2:0]     cursor_ff, cursor_in;
   logic [1:0]     page_ff, page_in;
   logic           armed_ff, armed_in;
   logic           commit_ff, commit_in;
   logic           match_ff, match_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic [3:0]     cursor_step;
   func_type       func;

   assign func        = func_type'(req_func);
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign cursor_step = {1'b0, cursor_ff} + 4'd1;

   // time_edit, alarm_edit, cursor, up
   assign adj_ctl = {time_edit_ff, alarm_edit_ff, cursor_ff, (func == FUNC_INCR)};

   cae_adjust u_adjust (
      .cur (fields_ff),
      .ctl (adj_ctl),
      .nxt (adjusted)
   );

   always_comb begin
      fields_in     = fields_ff;
      time_edit_in  = time_edit_ff;
      alarm_edit_in = alarm_edit_ff;
      cursor_in     = cursor_ff;
      page_in       = page_ff;
      armed_in      = armed_ff;
      commit_in     = 1'b0;
      case (func)
         FUNC_MODE: begin
            time_edit_in = 1'b1;
            cursor_in    = (cursor_step > 4'd6) ? CUR_YEAR : cursor_step[2:0];
            page_in      = (cursor_in <= CUR_DATE) ? PAGE_DATE : PAGE_TIME;
         end
         FUNC_INCR, FUNC_DECR: fields_in = adjusted;
         FUNC_SAVE: begin
            if (time_edit_ff) begin
               cursor_in    = CUR_NONE;
               time_edit_in = 1'b0;
               commit_in    = 1'b1;
            end else if (alarm_edit_ff) begin
               cursor_in     = CUR_NONE;
               alarm_edit_in = 1'b0;
               armed_in      = 1'b1;
            end
         end
         FUNC_EXIT: begin
            if (time_edit_ff) begin
               cursor_in    = CUR_NONE;
               time_edit_in = 1'b0;
            end else if (alarm_edit_ff) begin
               cursor_in     = CUR_NONE;
               alarm_edit_in = 1'b0;
               armed_in      = 1'b0;
            end
         end
         FUNC_ALARM: begin
            alarm_edit_in = 1'b1;
            page_in       = PAGE_ALARM;
            cursor_in     = (cursor_step > 4'd2) ? CUR_ALARM_HOUR : cursor_step[2:0];
         end
         FUNC_PAGE: page_in = page_ff + 2'd1;
         FUNC_LOAD: begin
            // drop the load while any edit is open
            if (!time_edit_ff && !alarm_edit_ff) begin
               fields_in.second = req_load_second;
               fields_in.minute = req_load_minute;
               fields_in.hour   = req_load_hour;
               fields_in.date   = req_load_date;
               fields_in.month  = req_load_month;
               fields_in.year   = req_load_year;
            end
         end
         default: fields_in = fields_ff;
      endcase
      match_in = armed_in && (fields_in.hour == fields_in.alarm_hour)
                 && (fields_in.minute == fields_in.alarm_minute);
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fields_ff.hour         <= 5'd23;
         fields_ff.minute       <= 6'd59;
         fields_ff.second       <= 6'd50;
         fields_ff.date         <= 5'd6;
         fields_ff.month        <= 4'd12;
         fields_ff.year         <= 7'd21;
         fields_ff.alarm_hour   <= 5'd0;
         fields_ff.alarm_minute <= 6'd0;
         time_edit_ff           <= 1'b0;
         alarm_edit_ff          <= 1'b0;
         cursor_ff              <= CUR_NONE;
         page_ff                <= PAGE_TIME;
         armed_ff               <= 1'b0;
         commit_ff              <= 1'b0;
         match_ff               <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fields_ff     <= fields_in;
            time_edit_ff  <= time_edit_in;
            alarm_edit_ff <= alarm_edit_in;
            cursor_ff     <= cursor_in;
            page_ff       <= page_in;
            armed_ff      <= armed_in;
            commit_ff     <= commit_in;
            match_ff      <= match_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cur_hour    = fields_ff.hour;
   assign rsp_cur_minute  = fields_ff.minute;
   assign rsp_cur_second  = fields_ff.second;
   assign rsp_cur_date    = fields_ff.date;
   assign rsp_cur_month   = fields_ff.month;
   assign rsp_cur_year    = fields_ff.year;
   assign rsp_wake_hour   = fields_ff.alarm_hour;
   assign rsp_wake_minute = fields_ff.alarm_minute;
   assign rsp_cursor      = cursor_ff;
   assign rsp_edit_modes  = {alarm_edit_ff, time_edit_ff};
   assign rsp_page        = page_ff;
   assign rsp_flags       = {match_ff, armed_ff, commit_ff};

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CUR_SECOND)
      else $error("cursor beyond last field");

   a_alarm_cursor: assert property (@(posedge clock) disable iff (reset)
      alarm_edit_ff && !time_edit_ff |-> cursor_ff <= CUR_ALARM_MINUTE)
      else $error("alarm edit cursor beyond alarm minute");

   a_commit_on_save: assert property (@(posedge clock) disable iff (reset)
      accept && func == FUNC_SAVE && time_edit_ff |=> commit_ff && !time_edit_ff
      && cursor_ff == CUR_NONE)
      else $error("save in time edit did not commit");

   a_match_needs_arm: assert property (@(posedge clock) disable iff (reset)
      match_ff |-> armed_ff && fields_ff.hour == fields_ff.alarm_hour)
      else $error("alarm match without arm or hour equality");

   a_commit_one_shot: assert property (@(posedge clock) disable iff (reset)
      accept && func != FUNC_SAVE |=> !commit_ff)
      else $error("commit flag outside save");

endmodule

`default_nettype wire

### src/cae_adjust.sv
// Increment or decrement of the field under the cursor, with per-field wrap.
`default_nettype none

module cae_adjust
   import cae_pkg::*;
(
   input  wire fields_type     cur,
   input  wire adjust_ctl_type ctl,
   output fields_type          nxt
);

   logic [6:0] date_len;
   logic [6:0] year_n;
   logic [6:0] month_n;
   logic [6:0] date_n;
   logic [6:0] hour_n;
   logic [6:0] minute_n;
   logic [6:0] second_n;
   logic [6:0] ahour_n;
   logic [6:0] aminute_n;

   assign date_len = month_length(cur.month, cur.year);

   always_comb begin
      year_n    = ctl.up ? wrap_up(cur.year, 7'd0, YEAR_MAX)
                         : wrap_down(cur.year, 7'd0, YEAR_MAX);
      month_n   = ctl.up ? wrap_up({3'd0, cur.month}, 7'd1, MONTH_MAX)
                         : wrap_down({3'd0, cur.month}, 7'd1, MONTH_MAX);
      date_n    = ctl.up ? wrap_up({2'd0, cur.date}, 7'd1, date_len)
                         : wrap_down({2'd0, cur.date}, 7'd1, date_len);
      hour_n    = ctl.up ? wrap_up({2'd0, cur.hour}, 7'd0, HOUR_MAX)
                         : wrap_down({2'd0, cur.hour}, 7'd0, HOUR_MAX);
      minute_n  = ctl.up ? wrap_up({1'b0, cur.minute}, 7'd0, MINUTE_MAX)
                         : wrap_down({1'b0, cur.minute}, 7'd0, MINUTE_MAX);
      second_n  = ctl.up ? wrap_up({1'b0, cur.second}, 7'd0, MINUTE_MAX)
                         : wrap_down({1'b0, cur.second}, 7'd0, MINUTE_MAX);
      ahour_n   = ctl.up ? wrap_up({2'd0, cur.alarm_hour}, 7'd0, HOUR_MAX)
                         : wrap_down({2'd0, cur.alarm_hour}, 7'd0, HOUR_MAX);
      aminute_n = ctl.up ? wrap_up({1'b0, cur.alarm_minute}, 7'd0, MINUTE_MAX)
                         : wrap_down({1'b0, cur.alarm_minute}, 7'd0, MINUTE_MAX);

      nxt = cur;
      // time edit wins when both edits are on
      if (ctl.time_edit) begin
         case (ctl.cursor)
            CUR_YEAR:   nxt.year   = year_n;
            CUR_MONTH:  nxt.month  = month_n[3:0];
            CUR_DATE:   nxt.date   = date_n[4:0];
            CUR_HOUR:   nxt.hour   = hour_n[4:0];
            CUR_MINUTE: nxt.minute = minute_n[5:0];
            CUR_SECOND: nxt.second = second_n[5:0];
            default:    nxt = cur;
         endcase
      end else if (ctl.alarm_edit) begin
         case (ctl.cursor)
            CUR_ALARM_HOUR:   nxt.alarm_hour   = ahour_n[4:0];
            CUR_ALARM_MINUTE: nxt.alarm_minute = aminute_n[5:0];
            default:          nxt = cur;
         endcase
      end
   end

endmodule

`default_nettype wire
